FILE: hw/rtl/positional_list_insert_remove_macros.svh
// Assertion macros for the positional list block.
// Depends on nothing; included by the files that carry assertions.
`ifndef POSITIONAL_LIST_INSERT_REMOVE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_REMOVE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define PLIR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("positional list assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define PLIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("positional list assertion failed");
`else
`define PLIR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PLIR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/plir_pkg.sv
// Package for the positional list block: sizes, field types and codes.
// Depends on nothing; imported by the top level.
package plir_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int LEN_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 7;
	localparam int CNT_W    = 7;
	localparam int VAL_W    = 32;
	localparam int CMP_W    = (LEN_W > POS_W) ? LEN_W : POS_W;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [CMP_W-1:0]  cmp_t;
	typedef logic [1:0]        status_t;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_EMPTY  = 2'd1;
	localparam status_t ST_BADPOS = 2'd2;
	localparam status_t ST_FULL   = 2'd3;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 40;

endpackage

FILE: hw/rtl/positional_list_insert_remove.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: command; tdata: position, value
// m_*       out  m_tvalid/m_tready  tuser: status; tdata: removed_value, entry_count
//
// A rejected item goes straight to the done state, and an insert at the end through the
// put state. A shifting remove passes through the shift and drain states and a shifting
// insert through the put state as well, paced by the single read and single write port
// of the entry memory, one entry a cycle.
// Reset clears the count and the control state; the entry memory is not cleared.
// Input is taken only in the idle state; a finished result waits while m_tready is low.
`include "positional_list_insert_remove_macros.svh"

module positional_list_insert_remove (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [6:0] position, [38:7] value, [39] zero
	input  logic [plir_pkg::IN_DATA_W-1:0]   s_tdata,
	// [0] command
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [31:0] removed_value, [38:32] entry_count, [39] zero
	output logic [plir_pkg::OUT_DATA_W-1:0]  m_tdata,
	// [1:0] status
	output logic [1:0]                       m_tuser
);
	import plir_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SHIFT = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_PUT   = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	len_t       len_q;
	logic       cmd_q;
	addr_t      addr_q;
	addr_t      pos_q;
	len_t       left_q;
	val_t       val_q;
	status_t    status_q;
	val_t       removed_q;

	logic       rd_s1;
	logic       first_s1;
	addr_t      wr_addr_s1;
	val_t       rdata_s1;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	status_t               out_user_q;

	val_t  mem [CAPACITY];
	logic  mem_we;
	logic  mem_re;
	addr_t mem_wa;
	val_t  mem_wd;

	logic    accept;
	pos_t    in_pos;
	val_t    in_val;
	status_t in_status;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_pos   = s_tdata[POS_W-1:0];
	assign in_val   = s_tdata[POS_W+VAL_W-1:POS_W];

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// Full and empty are checked before the position.
	always_comb begin
		in_status = ST_OK;
		if (s_tuser == CMD_INSERT) begin
			if (len_q == len_t'(CAPACITY)) begin
				in_status = ST_FULL;
			end else if (cmp_t'(in_pos) > cmp_t'(len_q)) begin
				in_status = ST_BADPOS;
			end
		end else begin
			if (len_q == '0) begin
				in_status = ST_EMPTY;
			end else if (cmp_t'(in_pos) >= cmp_t'(len_q)) begin
				in_status = ST_BADPOS;
			end
		end
	end

	// The first beat read by a remove is the removed entry and is not written back.
	always_comb begin
		mem_re = (state_q == S_SHIFT);
		if (state_q == S_PUT) begin
			mem_we = 1'b1;
			mem_wa = pos_q;
			mem_wd = val_q;
		end else begin
			mem_we = rd_s1 && !first_s1;
			mem_wa = wr_addr_s1;
			mem_wd = rdata_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_s1 <= mem[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= s_tuser;
			val_q     <= in_val;
			status_q  <= in_status;
			removed_q <= '0;
			pos_q     <= addr_t'(in_pos);
			left_q    <= len_t'(cmp_t'(len_q) - cmp_t'(in_pos));
			if (s_tuser == CMD_INSERT) begin
				addr_q <= addr_t'(len_q - len_t'(1));
			end else begin
				addr_q <= addr_t'(in_pos);
			end
		end else if (state_q == S_SHIFT) begin
			left_q     <= left_q - len_t'(1);
			first_s1   <= (cmd_q == CMD_REMOVE) && (addr_q == pos_q);
			wr_addr_s1 <= (cmd_q == CMD_INSERT) ? addr_q + addr_t'(1) : addr_q - addr_t'(1);
			addr_q     <= (cmd_q == CMD_INSERT) ? addr_q - addr_t'(1) : addr_q + addr_t'(1);
		end
		if (rd_s1 && first_s1) begin
			removed_q <= rdata_s1;
		end
		if ((state_q == S_DONE) && (!out_valid_q || m_tready)) begin
			out_user_q <= status_q;
			out_data_q <= {{(OUT_DATA_W - VAL_W - CNT_W){1'b0}}, cnt_t'(len_q), removed_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= (state_q == S_SHIFT);
			if (out_valid_q && m_tready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_status != ST_OK) begin
							state_q <= S_DONE;
						end else if ((s_tuser == CMD_INSERT) && (cmp_t'(in_pos) == cmp_t'(len_q))) begin
							state_q <= S_PUT;
						end else begin
							state_q <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					if (left_q == len_t'(1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (cmd_q == CMD_INSERT) begin
						state_q <= S_PUT;
					end else begin
						len_q   <= len_q - len_t'(1);
						state_q <= S_DONE;
					end
				end
				S_PUT: begin
					len_q   <= len_q + len_t'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`PLIR_ASSERT_NOW(a_len_bound, clk, arst_n, 1'b1, len_q <= len_t'(CAPACITY))
	`PLIR_ASSERT_NOW(a_no_rw_clash, clk, arst_n, (state_q == S_SHIFT) && mem_we, mem_wa != addr_q)
	`PLIR_ASSERT_NEXT(a_put_grows, clk, arst_n, state_q == S_PUT, len_q == $past(len_q) + len_t'(1))
	`PLIR_ASSERT_NOW(a_busy_no_ready, clk, arst_n, rd_s1, !s_tready)

endmodule

FILE: dv/tb_positional_list_insert_remove.sv
// Self-checking testbench for the positional list insert/remove block.
// Depends on plir_pkg and positional_list_insert_remove; a mirror of the list predicts
// every result beat, which is then checked field by field against the output stream.
module tb_positional_list_insert_remove;
	import plir_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 1200;

	typedef struct packed {
		status_t status;
		val_t    removed;
		cnt_t    count;
	} list_reply_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// [6:0] position, [38:7] value, [39] zero
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	// [0] command
	logic                  s_tuser = CMD_INSERT;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// [31:0] removed_value, [38:32] entry_count, [39] zero
	logic [OUT_DATA_W-1:0] m_tdata;
	// [1:0] status
	logic [1:0]            m_tuser;

	// Mirror of the list contents; only entries below mirror_len are meaningful.
	val_t        list_mirror [CAPACITY];
	int          mirror_len = 0;
	list_reply_t pending_replies [$];

	int fail_count = 0;
	int items_sent = 0;
	int burst_left = 0;
	bit sender_steady = 1'b0;
	int status_seen [4] = '{0, 0, 0, 0};

	positional_list_insert_remove dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #6 clk = ~clk;

	// Applies one item to the mirror and returns the result it should produce.
	function automatic list_reply_t list_apply(input logic cmd, input pos_t pos, input val_t val);
		list_reply_t r;
		int          p;
		int          i;
		p = int'(pos);
		r.status = ST_OK;
		r.removed = '0;
		if (cmd == CMD_INSERT) begin
			if (mirror_len >= CAPACITY) begin
				r.status = ST_FULL;
			end else if (p > mirror_len) begin
				r.status = ST_BADPOS;
			end else begin
				for (i = mirror_len; i > p; i--)
					list_mirror[i] = list_mirror[i-1];
				list_mirror[p] = val;
				mirror_len++;
			end
		end else begin
			if (mirror_len == 0) begin
				r.status = ST_EMPTY;
			end else if (p >= mirror_len) begin
				r.status = ST_BADPOS;
			end else begin
				r.removed = list_mirror[p];
				for (i = p; i + 1 < mirror_len; i++)
					list_mirror[i] = list_mirror[i+1];
				mirror_len--;
			end
		end
		r.count = cnt_t'(mirror_len);
		return r;
	endfunction

	// Sends one beat, idling between bursts unless the sender is in a steady stretch.
	task automatic send_item(input logic cmd, input pos_t pos, input val_t val);
		if (!sender_steady) begin
			if (burst_left == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end
			burst_left--;
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {1'b0, val, pos};
		do @(posedge clk); while (!s_tready);
		pending_replies.push_back(list_apply(cmd, pos, val));
		items_sent++;
	endtask

	// Holds the sender off until every outstanding result has been checked.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_replies.size() != 0);
	endtask

	function automatic val_t pick_value();
		case ($urandom_range(0, 11))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Mostly in-range positions, sometimes the boundary, sometimes anything the field holds.
	function automatic pos_t pick_position(input logic cmd);
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return pos_t'($urandom_range(0, 127));
		if (r < 14)
			return pos_t'(mirror_len);
		if (cmd == CMD_INSERT)
			return pos_t'($urandom_range(0, mirror_len));
		if (mirror_len == 0)
			return '0;
		return pos_t'($urandom_range(0, mirror_len - 1));
	endfunction

	task automatic send_random(input int insert_bias);
		logic cmd;
		cmd = ($urandom_range(0, 99) < insert_bias) ? CMD_INSERT : CMD_REMOVE;
		send_item(cmd, pick_position(cmd), pick_value());
	endtask

	task automatic test_reset();
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// Empty list, bad positions, extreme values and removal from each end.
	task automatic test_directed();
		sender_steady = 1'b1;
		send_item(CMD_REMOVE, 7'd0,   $urandom);
		send_item(CMD_REMOVE, 7'd127, $urandom);
		send_item(CMD_INSERT, 7'd1,   32'd5);
		send_item(CMD_INSERT, 7'd127, 32'd6);
		send_item(CMD_INSERT, 7'd0,   32'h8000_0000);
		send_item(CMD_INSERT, 7'd1,   32'h7FFF_FFFF);
		send_item(CMD_INSERT, 7'd0,   32'hFFFF_FFFF);
		send_item(CMD_INSERT, 7'd1,   32'h0000_0000);
		send_item(CMD_INSERT, 7'd2,   32'h1234_5678);
		send_item(CMD_INSERT, 7'd5,   32'hA5A5_A5A5);
		send_item(CMD_INSERT, 7'd7,   32'h5A5A_5A5A);
		send_item(CMD_REMOVE, 7'd6,   $urandom);
		send_item(CMD_REMOVE, 7'd64,  $urandom);
		send_item(CMD_REMOVE, 7'd127, $urandom);
		send_item(CMD_REMOVE, 7'd2,   $urandom);
		send_item(CMD_REMOVE, 7'd4,   $urandom);
		send_item(CMD_REMOVE, 7'd0,   $urandom);
		repeat (3) send_item(CMD_REMOVE, 7'd0, $urandom);
		send_item(CMD_REMOVE, 7'd0,   $urandom);
		sender_steady = 1'b0;
		wait_drained();
	endtask

	// Fills the list to capacity, probes it while full, then drains it again.
	task automatic test_full_list();
		while (mirror_len < CAPACITY)
			send_item(CMD_INSERT, pos_t'($urandom_range(0, mirror_len)), $urandom);
		send_item(CMD_INSERT, 7'd0,   $urandom);
		send_item(CMD_INSERT, 7'd64,  $urandom);
		send_item(CMD_INSERT, 7'd127, $urandom);
		send_item(CMD_REMOVE, 7'd64,  $urandom);
		send_item(CMD_REMOVE, 7'd63,  $urandom);
		send_item(CMD_INSERT, 7'd63,  32'h8000_0000);
		while (mirror_len > 0)
			send_item(CMD_REMOVE, pos_t'($urandom_range(0, mirror_len - 1)), $urandom);
		send_item(CMD_REMOVE, 7'd0, $urandom);
		wait_drained();
	endtask

	// Phases of different insert bias so the list wanders between empty and full.
	task automatic test_random();
		int sent;
		int phase_len;
		int bias;
		int n;
		sent = 0;
		n = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 3))
				0: begin bias = 85; phase_len = $urandom_range(60, 120); end
				1: begin bias = 15; phase_len = $urandom_range(60, 120); end
				2: begin bias = 50; phase_len = $urandom_range(80, 160); end
				default: begin bias = -1; phase_len = $urandom_range(60, 120); end
			endcase
			if (phase_len > RANDOM_ITEMS - sent)
				phase_len = RANDOM_ITEMS - sent;
			sender_steady = ($urandom_range(0, 3) == 0);
			repeat (phase_len) begin
				// A bias of -1 hovers around the full boundary.
				if (bias < 0)
					send_random((mirror_len > CAPACITY - 6) ? 45 : 90);
				else
					send_random(bias);
				sent++;
			end
			sender_steady = 1'b0;
			if (n == 0 || $urandom_range(0, 2) == 0)
				wait_drained();
			n++;
		end
		s_tvalid <= 1'b0;
	endtask

	// Receiver stalls: always ready, coin toss, mostly stalled, alternating ready and stall bursts.
	int rx_cycle = 0;
	int rx_hold = 0;
	always @(posedge clk) begin
		rx_cycle++;
		case ((rx_cycle / 300) % 4)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: begin
				if (rx_hold == 0) begin
					rx_hold = $urandom_range(1, 12);
					m_tready <= ~m_tready;
				end
				rx_hold--;
			end
		endcase
	end

	always @(posedge clk) begin : check_reply
		list_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: result beat with nothing expected: status %0d data %h",
					$time, m_tuser, m_tdata);
				fail_count++;
			end else begin
				want = pending_replies.pop_front();
				status_seen[want.status]++;
				if (m_tuser != want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, m_tuser);
					fail_count++;
				end
				if (m_tdata[31:0] != want.removed) begin
					$display("%0t: removed_value expected %h actual %h",
						$time, want.removed, m_tdata[31:0]);
					fail_count++;
				end
				if (m_tdata[38:32] != want.count) begin
					$display("%0t: entry_count expected %0d actual %0d",
						$time, want.count, m_tdata[38:32]);
					fail_count++;
				end
			end
		end
	end

	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles, %0d results outstanding",
				$time, idle_cycles, pending_replies.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		test_reset();
		test_directed();
		test_full_list();
		test_random();
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("Sent %0d items; results ok %0d, empty %0d, bad position %0d, full %0d.",
			items_sent, status_seen[ST_OK], status_seen[ST_EMPTY],
			status_seen[ST_BADPOS], status_seen[ST_FULL]);
		$display("Covered empty and full boundaries, extreme values and input/output stalls.");
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
